[rtl/assert_macros.svh]
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent property, clocked on clk, held off while rst_n is low
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// expression that must never be true
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  `ASSERT_PROP(label, clk, rst_n, !(expr))

`endif

[rtl/fsbc_pkg.sv]
// types and constants of the frustum cull block
// no dependencies
package fsbc_pkg;

  localparam int NumPlanes     = 6;
  localparam int NumSidePlanes = 4;
  localparam int NumAxes       = 3;
  localparam int PlaneWidth    = 64;
  localparam int NormWidth     = 16;
  localparam int FracBits      = 14;
  localparam int CfgIdxWidth   = 3;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_PLANE_RIGHT  = 3'd0,
    CFG_PLANE_LEFT   = 3'd1,
    CFG_PLANE_TOP    = 3'd2,
    CFG_PLANE_BOTTOM = 3'd3,
    CFG_PLANE_FAR    = 3'd4,
    CFG_PLANE_NEAR   = 3'd5,
    CFG_IGNORE_DEPTH = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    REQ_SPHERE = 1'b0,
    REQ_BOX    = 1'b1
  } req_type_e;

  typedef struct packed {
    logic signed [NormWidth-1:0] d;
    logic signed [NormWidth-1:0] nz;
    logic signed [NormWidth-1:0] ny;
    logic signed [NormWidth-1:0] nx;
  } plane_t;

  typedef struct packed {
    logic load_prod;
    logic load_sum;
  } fsbc_adv_t;

endpackage

[rtl/fsbc_intf.sv]
// handshake channels of the frustum cull block: request, result, config write
// depends on fsbc_pkg
interface fsbc_req_if #(
  parameter int CoordWidth = 16
) ();
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic signed [CoordWidth-1:0] first_x;
  logic signed [CoordWidth-1:0] first_y;
  logic signed [CoordWidth-1:0] first_z;
  logic signed [CoordWidth-1:0] second_x;
  logic signed [CoordWidth-1:0] second_y;
  logic signed [CoordWidth-1:0] second_z;
  logic [CoordWidth-2:0]        radius;
  logic                         last_object;

  modport source (
    output valid, req_type, first_x, first_y, first_z,
    output second_x, second_y, second_z, radius, last_object,
    input  ready
  );
  modport sink (
    input  valid, req_type, first_x, first_y, first_z,
    input  second_x, second_y, second_z, radius, last_object,
    output ready
  );
endinterface

interface fsbc_rsp_if ();
  logic valid;
  logic ready;
  logic culled;
  logic last_flag;

  modport source (output valid, culled, last_flag, input ready);
  modport sink (input valid, culled, last_flag, output ready);
endinterface

interface fsbc_cfg_if ();
  logic                             valid;
  logic                             ready;
  logic [fsbc_pkg::CfgIdxWidth-1:0] index;
  logic [fsbc_pkg::PlaneWidth-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/fsbc_plane_lane.sv]
// one plane lane: products, partial sums and the outside test for one plane
// depends on fsbc_pkg
module fsbc_plane_lane #(
  parameter int CoordWidth = 16
) (
  input  logic                         clk_i,
  input  fsbc_pkg::fsbc_adv_t          adv_i,
  input  fsbc_pkg::plane_t             plane_i,
  input  logic signed [CoordWidth-1:0] first_i  [fsbc_pkg::NumAxes],
  input  logic signed [CoordWidth-1:0] second_i [fsbc_pkg::NumAxes],
  input  logic                         is_box_i,
  input  logic [CoordWidth-2:0]        radius_i,
  output logic                         hit_o
);
  import fsbc_pkg::*;

  localparam int ProdWidth = CoordWidth + NormWidth;
  localparam int SumWidth  = ((ProdWidth > 30) ? ProdWidth : 30) + 3;

  logic signed [NormWidth-1:0] norm    [NumAxes];
  logic signed [ProdWidth-1:0] prod_a_d [NumAxes];
  logic signed [ProdWidth-1:0] prod_b_d [NumAxes];
  logic signed [ProdWidth-1:0] prod_a_q [NumAxes];
  logic signed [ProdWidth-1:0] prod_b_q [NumAxes];
  logic signed [ProdWidth-1:0] term    [NumAxes];
  logic signed [SumWidth-1:0]  off_ext;
  logic signed [SumWidth-1:0]  rad_ext;
  logic signed [SumWidth-1:0]  sum_xy_d, sum_xy_q;
  logic signed [SumWidth-1:0]  sum_zb_d, sum_zb_q;
  logic signed [SumWidth-1:0]  total;

  assign norm[0] = plane_i.nx;
  assign norm[1] = plane_i.ny;
  assign norm[2] = plane_i.nz;

  always_comb begin
    for (int k = 0; k < NumAxes; k++) begin
      prod_a_d[k] = ProdWidth'(norm[k]) * ProdWidth'(first_i[k]);
      prod_b_d[k] = ProdWidth'(norm[k]) * ProdWidth'(second_i[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.load_prod) begin
      prod_a_q <= prod_a_d;
      prod_b_q <= prod_b_d;
    end
  end

  // box takes the larger product per axis, sphere the center product
  always_comb begin
    for (int k = 0; k < NumAxes; k++) begin
      if (is_box_i && (prod_b_q[k] > prod_a_q[k])) begin
        term[k] = prod_b_q[k];
      end else begin
        term[k] = prod_a_q[k];
      end
    end
  end

  assign off_ext  = SumWidth'(plane_i.d) <<< FracBits;
  assign rad_ext  = SumWidth'({1'b0, radius_i}) <<< FracBits;
  assign sum_xy_d = SumWidth'(term[0]) + SumWidth'(term[1]);
  assign sum_zb_d = SumWidth'(term[2]) + off_ext + rad_ext;

  always_ff @(posedge clk_i) begin
    if (adv_i.load_sum) begin
      sum_xy_q <= sum_xy_d;
      sum_zb_q <= sum_zb_d;
    end
  end

  assign total = sum_xy_q + sum_zb_q;
  assign hit_o = total[SumWidth-1] || (total == '0);

endmodule

[rtl/frustum_sphere_box_cull_top.sv]
// throughput: one volume per cycle while rsp_o is ready, 36 plane multipliers work in parallel
// stages: input register, products, partial sums, result register
// a stall on rsp_o holds every occupied stage, bubbles still close up
// reset clears the stage valid bits and all plane registers to zero
module frustum_sphere_box_cull_top #(
  parameter int COORD_WIDTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fsbc_req_if.sink   req_i,
  fsbc_rsp_if.source rsp_o,
  fsbc_cfg_if.sink   cfg_i
);
  import fsbc_pkg::*;

  plane_t                        planes_q [NumPlanes];
  logic                          ignore_depth_q;

  logic                          v1_q, v2_q, v3_q, v4_q;
  logic                          en1, en2, en3, en4;
  fsbc_adv_t                     adv;

  logic                          is_box1_q, is_box2_q;
  logic signed [COORD_WIDTH-1:0] first1_q  [NumAxes];
  logic signed [COORD_WIDTH-1:0] second1_q [NumAxes];
  logic [COORD_WIDTH-2:0]        radius1_q, radius2_q;
  logic                          last1_q, last2_q, last3_q;
  logic [NumPlanes-1:0]          hit;
  logic [NumPlanes-1:0]          mask;
  logic                          culled_q, last4_q;

  // config writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NumPlanes; p++) begin
        planes_q[p] <= '0;
      end
      ignore_depth_q <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_PLANE_RIGHT:  planes_q[0] <= plane_t'(cfg_i.data);
        CFG_PLANE_LEFT:   planes_q[1] <= plane_t'(cfg_i.data);
        CFG_PLANE_TOP:    planes_q[2] <= plane_t'(cfg_i.data);
        CFG_PLANE_BOTTOM: planes_q[3] <= plane_t'(cfg_i.data);
        CFG_PLANE_FAR:    planes_q[4] <= plane_t'(cfg_i.data);
        CFG_PLANE_NEAR:   planes_q[5] <= plane_t'(cfg_i.data);
        CFG_IGNORE_DEPTH: ignore_depth_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // stage enables
  assign en4 = !v4_q || rsp_o.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign req_i.ready   = en1;
  assign adv.load_prod = en2;
  assign adv.load_sum  = en3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= req_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      is_box1_q    <= (req_type_e'(req_i.req_type) == REQ_BOX);
      first1_q[0]  <= req_i.first_x;
      first1_q[1]  <= req_i.first_y;
      first1_q[2]  <= req_i.first_z;
      second1_q[0] <= req_i.second_x;
      second1_q[1] <= req_i.second_y;
      second1_q[2] <= req_i.second_z;
      radius1_q    <= req_i.radius;
      last1_q      <= req_i.last_object;
    end
    if (en2) begin
      is_box2_q <= is_box1_q;
      radius2_q <= is_box1_q ? '0 : radius1_q;
      last2_q   <= last1_q;
    end
    if (en3) begin
      last3_q <= last2_q;
    end
    if (en4) begin
      culled_q <= |(hit & mask);
      last4_q  <= last3_q;
    end
  end

  for (genvar p = 0; p < NumPlanes; p++) begin : g_lane
    fsbc_plane_lane #(
      .CoordWidth(COORD_WIDTH)
    ) u_lane (
      .clk_i    (clk_i),
      .adv_i    (adv),
      .plane_i  (planes_q[p]),
      .first_i  (first1_q),
      .second_i (second1_q),
      .is_box_i (is_box2_q),
      .radius_i (radius2_q),
      .hit_o    (hit[p])
    );
    assign mask[p] = (p < NumSidePlanes) || !ignore_depth_q;
  end

  assign rsp_o.valid     = v4_q;
  assign rsp_o.culled    = culled_q;
  assign rsp_o.last_flag = last4_q;

endmodule

[rtl/fsbc_checker.sv]
// port-level checks of the frustum cull block, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module fsbc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_culled_i,
  input logic out_last_i
);

  logic       in_acc;
  logic       out_acc;
  logic [2:0] cnt_d, cnt_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;
  assign cnt_d   = cnt_q + 3'(in_acc) - 3'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  `ASSERT_NEVER(a_no_invented_result, clk_i, rst_ni, out_valid_i && (cnt_q == 3'd0))
  `ASSERT_NEVER(a_occupancy_bound, clk_i, rst_ni, cnt_q > 3'd4)
  `ASSERT_PROP(a_empty_latency, clk_i, rst_ni, in_acc && (cnt_q == 3'd0) |=> ##3 out_valid_i)
  `ASSERT_PROP(a_stall_holds, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_culled_i) && $stable(out_last_i))

endmodule

bind frustum_sphere_box_cull_top fsbc_checker u_fsbc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .out_culled_i (rsp_o.culled),
  .out_last_i   (rsp_o.last_flag)
);

[sim/tb.sv]
`timescale 1ns / 1ps
// self-checking bench for frustum_sphere_box_cull_top: directed and random volumes
// against a local cull predictor; depends on fsbc_pkg, fsbc_intf and the top level rtl
module tb;
  import fsbc_pkg::*;

  localparam int          CoordW        = 16;
  localparam longint      FracScale     = longint'(1) << FracBits;
  localparam int          UnitNorm      = 1 << FracBits;
  localparam int          UnitHalf      = 1000;
  localparam int          NumPhases     = 8;
  localparam int          ItemsPerPhase = 190;
  localparam int          DrainCycles   = 8;
  localparam int          MaxReports    = 10;
  localparam logic [CfgIdxWidth-1:0] CfgIdxSpare = '1;

  typedef enum int {
    FR_UNIT, FR_SANE, FR_RAW, FR_MAX, FR_MIN, FR_ONES, FR_ZERO, FR_MIXED
  } frustum_kind_e;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct {
    req_type_e                kind;
    logic signed [CoordW-1:0] lo [NumAxes];
    logic signed [CoordW-1:0] hi [NumAxes];
    logic [CoordW-2:0]        radius;
    logic                     last_object;
  } volume_t;

  typedef struct {
    logic culled;
    logic last_flag;
  } cull_result_t;

  class cull_scoreboard;
    plane_t       planes [NumPlanes];
    logic         depth_off;
    cull_result_t pending_culls [$];
    int unsigned  mismatches;
    int unsigned  checked;
    int unsigned  culled_seen;
    int unsigned  spheres;
    int unsigned  boxes;

    function new();
      foreach (planes[i]) planes[i] = '0;
      depth_off   = 1'b0;
      mismatches  = 0;
      checked     = 0;
      culled_seen = 0;
      spheres     = 0;
      boxes       = 0;
    endfunction

    function void write_reg(logic [CfgIdxWidth-1:0] idx, logic [PlaneWidth-1:0] data);
      if (idx < NumPlanes) planes[idx] = plane_t'(data);
      else if (idx == CFG_IGNORE_DEPTH) depth_off = data[0];
    endfunction

    function longint prod(logic signed [NormWidth-1:0] n, logic signed [CoordW-1:0] c);
      return longint'(n) * longint'(c);
    endfunction

    function longint larger(longint a, longint b);
      return (a > b) ? a : b;
    endfunction

    function cull_result_t cull_verdict(volume_t v);
      cull_result_t res;
      plane_t       p;
      longint       s;
      longint       bias;
      int           count;
      res.culled    = 1'b0;
      res.last_flag = v.last_object;
      count = depth_off ? NumSidePlanes : NumPlanes;
      for (int i = 0; i < count; i++) begin
        p    = planes[i];
        bias = longint'(p.d) * FracScale;
        if (v.kind == REQ_BOX) begin
          s = larger(prod(p.nx, v.lo[0]), prod(p.nx, v.hi[0]))
            + larger(prod(p.ny, v.lo[1]), prod(p.ny, v.hi[1]))
            + larger(prod(p.nz, v.lo[2]), prod(p.nz, v.hi[2])) + bias;
          if (s <= 0) res.culled = 1'b1;
        end else begin
          s = prod(p.nx, v.lo[0]) + prod(p.ny, v.lo[1]) + prod(p.nz, v.lo[2]) + bias;
          if (s <= -(longint'(v.radius) * FracScale)) res.culled = 1'b1;
        end
      end
      return res;
    endfunction

    function void note_volume(volume_t v);
      if (v.kind == REQ_BOX) boxes++;
      else spheres++;
      pending_culls.push_back(cull_verdict(v));
    endfunction

    function void check_result(logic culled, logic last_flag);
      cull_result_t want;
      if (pending_culls.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: unexpected result culled=%0b last=%0b", $realtime, culled,
                   last_flag);
        return;
      end
      want = pending_culls.pop_front();
      checked++;
      if (culled === 1'b1) culled_seen++;
      if (want.culled !== culled || want.last_flag !== last_flag) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: mismatch expected culled=%0b last=%0b, got culled=%0b last=%0b",
                   $realtime, want.culled, want.last_flag, culled, last_flag);
      end
    endfunction

    function int unsigned pending();
      return pending_culls.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  fsbc_req_if #(.CoordWidth(CoordW)) req ();
  fsbc_rsp_if                        rsp ();
  fsbc_cfg_if                        cfg ();

  frustum_sphere_box_cull_top #(.COORD_WIDTH(CoordW)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp),
    .cfg_i  (cfg)
  );

  cull_scoreboard sb = new();
  int unsigned    send_idle_pct  = 0;
  int unsigned    recv_stall_pct = 0;
  int unsigned    settings       = 0;
  frustum_kind_e  phase_kinds [NumPhases] = '{FR_SANE, FR_RAW, FR_SANE, FR_MAX,
                                              FR_MIXED, FR_MIN, FR_SANE, FR_ONES};

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // result side: check each transaction, then pick ready for the next cycle
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp.valid && rsp.ready) sb.check_result(rsp.culled, rsp.last_flag);
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic signed [CoordW-1:0] rand_coord(int span);
    if (span == 0) return CoordW'($urandom);
    return CoordW'(int'($urandom_range(2 * span)) - span);
  endfunction

  function automatic volume_t rand_volume();
    volume_t                  v;
    int                       span;
    logic signed [CoordW-1:0] t;
    case ($urandom_range(3))
      0:       span = 0;
      1:       span = 4096;
      2:       span = 512;
      default: span = 64;
    endcase
    v.kind = req_type_e'($urandom_range(1));
    for (int a = 0; a < NumAxes; a++) begin
      v.lo[a] = rand_coord(span);
      v.hi[a] = rand_coord(span);
    end
    v.radius      = (span == 0) ? (CoordW - 1)'($urandom) : (CoordW - 1)'($urandom_range(span));
    v.last_object = ($urandom_range(7) == 0);
    // mostly ordered boxes, the rest stay inverted on some axes
    if (v.kind == REQ_BOX && $urandom_range(9) != 0) begin
      for (int a = 0; a < NumAxes; a++) begin
        if (v.lo[a] > v.hi[a]) begin
          t       = v.lo[a];
          v.lo[a] = v.hi[a];
          v.hi[a] = t;
        end
      end
    end
    return v;
  endfunction

  function automatic volume_t sphere(int x, int y, int z, int r, logic last);
    volume_t v;
    v = rand_volume();
    v.kind        = REQ_SPHERE;
    v.lo[0]       = CoordW'(x);
    v.lo[1]       = CoordW'(y);
    v.lo[2]       = CoordW'(z);
    v.radius      = (CoordW - 1)'(r);
    v.last_object = last;
    return v;
  endfunction

  function automatic volume_t box(int lx, int ly, int lz, int hx, int hy, int hz,
                                  logic last);
    volume_t v;
    v = rand_volume();
    v.kind        = REQ_BOX;
    v.lo[0]       = CoordW'(lx);
    v.lo[1]       = CoordW'(ly);
    v.lo[2]       = CoordW'(lz);
    v.hi[0]       = CoordW'(hx);
    v.hi[1]       = CoordW'(hy);
    v.hi[2]       = CoordW'(hz);
    v.last_object = last;
    return v;
  endfunction

  function automatic logic [PlaneWidth-1:0] plane_value(frustum_kind_e kind, int idx);
    logic signed [NormWidth-1:0] n [NumAxes];
    logic signed [NormWidth-1:0] d;
    case (kind)
      FR_UNIT: begin
        foreach (n[a]) n[a] = '0;
        // even planes face -axis, odd planes face +axis
        n[idx / 2] = NormWidth'((idx % 2) ? UnitNorm : -UnitNorm);
        d = NormWidth'(UnitHalf);
      end
      FR_SANE: begin
        foreach (n[a]) n[a] = NormWidth'(int'($urandom_range(2 * UnitNorm)) - UnitNorm);
        d = NormWidth'(int'($urandom_range(40767)) - 8000);
      end
      FR_RAW:   return {$urandom, $urandom};
      FR_MAX:   return {4{16'h7FFF}};
      FR_MIN:   return {4{16'h8000}};
      FR_ONES:  return '1;
      FR_ZERO:  return '0;
      default:  return plane_value(frustum_kind_e'($urandom_range(FR_SANE, FR_ZERO)), idx);
    endcase
    return {d, n[2], n[1], n[0]};
  endfunction

  task automatic cfg_write(logic [CfgIdxWidth-1:0] idx, logic [PlaneWidth-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic load_frustum(frustum_kind_e kind, logic depth_off);
    logic [PlaneWidth-1:0] word;
    for (int i = 0; i < NumPlanes; i++) cfg_write(cfg_idx_e'(i), plane_value(kind, i));
    word    = {$urandom, $urandom};
    word[0] = depth_off;
    cfg_write(CFG_IGNORE_DEPTH, word);
    // unmapped index must leave every register alone
    cfg_write(CfgIdxSpare, {$urandom, $urandom});
    cfg.valid <= 1'b0;
    settings++;
  endtask

  task automatic set_idle(idle_mode_e mode);
    case (mode)
      IDLE_SEND: begin send_idle_pct = 51; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 51; end
      IDLE_BOTH: begin send_idle_pct = 19; recv_stall_pct = 19; end
      default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  task automatic send_volume(volume_t v);
    if ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    req.valid       <= 1'b1;
    req.req_type    <= v.kind;
    req.first_x     <= v.lo[0];
    req.first_y     <= v.lo[1];
    req.first_z     <= v.lo[2];
    req.second_x    <= v.hi[0];
    req.second_y    <= v.hi[1];
    req.second_z    <= v.hi[2];
    req.radius      <= v.radius;
    req.last_object <= v.last_object;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    sb.note_volume(v);
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    rst_ni          = 1'b0;
    req.valid       = 1'b0;
    req.req_type    = REQ_SPHERE;
    req.first_x     = '0;
    req.first_y     = '0;
    req.first_z     = '0;
    req.second_x    = '0;
    req.second_y    = '0;
    req.second_z    = '0;
    req.radius      = '0;
    req.last_object = 1'b0;
    cfg.valid       = 1'b0;
    cfg.index       = '0;
    cfg.data        = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all-zero planes after reset
    set_idle(IDLE_NONE);
    send_volume(sphere(0, 0, 0, 0, 1'b0));
    send_volume(sphere(32767, -32768, 0, 32767, 1'b1));
    send_volume(box(0, 0, 0, 0, 0, 0, 1'b0));
    send_volume(box(-32768, -32768, -32768, 32767, 32767, 32767, 1'b1));
    req.valid <= 1'b0;
    drain();

    // cube frustum, boundaries and extremes
    load_frustum(FR_UNIT, 1'b0);
    send_volume(sphere(0, 0, 0, 0, 1'b0));
    send_volume(sphere(UnitHalf, 0, 0, 0, 1'b0));
    send_volume(sphere(UnitHalf + 1, 0, 0, 1, 1'b0));
    send_volume(sphere(UnitHalf + 1, 0, 0, 2, 1'b1));
    send_volume(sphere(-32768, -32768, -32768, 32767, 1'b0));
    send_volume(sphere(32767, 32767, 32767, 0, 1'b0));
    send_volume(sphere(0, 0, 5000, 0, 1'b0));
    send_volume(box(-10, -10, -10, 10, 10, 10, 1'b0));
    send_volume(box(UnitHalf, 0, 0, 2000, 5, 5, 1'b0));
    send_volume(box(500, 500, 500, -500, -500, -500, 1'b0));
    send_volume(box(-32768, -32768, -32768, 32767, 32767, 32767, 1'b0));
    send_volume(box(32767, 32767, 32767, -32768, -32768, -32768, 1'b1));
    send_volume(box(0, 0, 2000, 0, 0, 3000, 1'b0));
    req.valid <= 1'b0;
    drain();

    // same cube, depth planes off
    load_frustum(FR_UNIT, 1'b1);
    send_volume(sphere(0, 0, 5000, 0, 1'b0));
    send_volume(box(0, 0, 2000, 0, 0, 3000, 1'b1));
    send_volume(sphere(0, UnitHalf, -32768, 0, 1'b0));
    req.valid <= 1'b0;

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      load_frustum(phase_kinds[ph], logic'(ph % 2));
      set_idle(idle_mode_e'(ph % 4));
      repeat (ItemsPerPhase) send_volume(rand_volume());
      req.valid <= 1'b0;
    end
    drain();

    $display("covered %0d spheres and %0d boxes over %0d plane settings",
             sb.spheres, sb.boxes, settings);
    $display("%0d results checked, %0d culled, %0d mismatches, %0d missing",
             sb.checked, sb.culled_seen, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/fsbc_pkg.sv
rtl/fsbc_intf.sv
rtl/fsbc_plane_lane.sv
rtl/frustum_sphere_box_cull_top.sv
rtl/fsbc_checker.sv
sim/tb.sv
